[rtl/core/dtf_pkg.sv]
// Shared types, float constants and controller/datapath command types for the text-to-float core.
package dtf_pkg;

	localparam int unsigned MaxDigits = 16;

	// single precision constants
	localparam logic [31:0] FP_ZERO  = 32'h0000_0000;
	localparam logic [31:0] FP_ONE   = 32'h3F80_0000;
	localparam logic [31:0] FP_TEN   = 32'h4120_0000;
	localparam logic [31:0] FP_TENTH = 32'h3DCC_CCCD;

	// index of the table slot that holds 1.0 and of the point's own slot
	localparam logic [4:0] POW_ONE_IDX   = 5'd15;
	localparam logic [4:0] POW_POINT_IDX = 5'd16;
	// index of the last of the table entries that are computed after reset
	localparam logic [4:0] INIT_LAST = 5'd29;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] value_bits;
		logic        too_long;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_INIT_ISSUE,
		ST_INIT_WAIT,
		ST_LOAD,
		ST_CHECK,
		ST_EVAL_ISSUE,
		ST_EVAL_WAIT,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {A_POW, A_ACC_A, A_ACC_P, A_ACC_Q} a_sel_t;
	typedef enum logic [1:0] {B_DIGIT, B_ONE, B_TEN, B_TENTH} b_sel_t;
	typedef enum logic [1:0] {C_ZERO, C_ACC_A, C_ACC_B, C_ACC_Q} c_sel_t;
	typedef enum logic [2:0] {D_ACC_A, D_ACC_B, D_ACC_P, D_ACC_Q, D_TABLE} dst_t;

	typedef struct packed {
		logic       load_en;
		logic       issue;
		logic       use_lane;
		logic [3:0] lane;
		logic [4:0] tbl_rd;
		logic [4:0] tbl_wr;
		a_sel_t     a_sel;
		b_sel_t     b_sel;
		c_sel_t     c_sel;
		dst_t       dst;
		logic       out_load;
		logic       clear;
	} dtf_cmd_t;

	typedef struct packed {
		logic last_acc;
		logic overflow;
		logic fma_done;
		logic out_full;
	} dtf_status_t;

endpackage

[rtl/core/dtf_fma.sv]
// Three-stage single precision fused multiply-add for non-negative normal or zero operands.
module dtf_fma (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        issue,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	input  logic [31:0] op_c,
	output logic        done,
	output logic [31:0] res
);
	import dtf_pkg::*;

	// stage 1: mantissa product
	logic        v_s1, v_s2, v_s3;
	logic [47:0] prod_s1;
	logic [9:0]  ep_s1;
	logic        pz_s1;
	logic [31:0] c_s1;

	logic a_zero, b_zero;
	assign a_zero = (op_a[30:23] == 8'd0);
	assign b_zero = (op_b[30:23] == 8'd0);

	always_ff @(posedge clk) begin
		prod_s1 <= {1'b1, op_a[22:0]} * {1'b1, op_b[22:0]};
		ep_s1   <= {2'b0, op_a[30:23]} + {2'b0, op_b[30:23]} - 10'd127;
		pz_s1   <= a_zero | b_zero;
		c_s1    <= op_c;
	end

	// stage 2: alignment of the smaller addend
	logic [49:0] big_s2, small_s2;
	logic        sticky_s2;
	logic [9:0]  emax_s2;
	logic        passc_s2;
	logic [31:0] c_s2;

	logic        c_zero;
	logic [9:0]  ec, diff, emax;
	logic [47:0] mc, big, lesser;
	logic [5:0]  sh;
	logic [49:0] smallx, mask;

	always_comb begin
		c_zero = (c_s1[30:23] == 8'd0);
		ec     = {2'b0, c_s1[30:23]};
		mc     = {1'b0, 1'b1, c_s1[22:0], 23'd0};
		if (c_zero) begin
			big    = prod_s1;
			lesser = 48'd0;
			diff   = 10'd0;
			emax   = ep_s1;
		end else if (ep_s1 >= ec) begin
			big    = prod_s1;
			lesser = mc;
			diff   = ep_s1 - ec;
			emax   = ep_s1;
		end else begin
			big    = mc;
			lesser = prod_s1;
			diff   = ec - ep_s1;
			emax   = ec;
		end
		sh     = (diff > 10'd50) ? 6'd50 : diff[5:0];
		smallx = {lesser, 2'b00};
		mask   = ~({50{1'b1}} << sh);
	end

	always_ff @(posedge clk) begin
		big_s2    <= {big, 2'b00};
		small_s2  <= smallx >> sh;
		sticky_s2 <= |(smallx & mask);
		emax_s2   <= emax;
		passc_s2  <= pz_s1;
		c_s2      <= c_s1;
	end

	// stage 3: add, one-step normalize, round to nearest even
	logic [31:0] res_s3;
	logic [50:0] sum, norm;
	logic [1:0]  lsel;
	logic [9:0]  exp_n;
	logic [23:0] mant;
	logic        guard, rest, rnd;
	logic [31:0] packed_res;

	always_comb begin
		sum = {1'b0, big_s2} + {1'b0, small_s2};
		if (sum[50]) begin
			lsel = 2'd2;
		end else if (sum[49]) begin
			lsel = 2'd1;
		end else begin
			lsel = 2'd0;
		end
		norm       = sum << (2'd2 - lsel);
		mant       = norm[50:27];
		guard      = norm[26];
		rest       = (|norm[25:0]) | sticky_s2;
		rnd        = guard & (rest | mant[0]);
		exp_n      = emax_s2 + {8'd0, lsel};
		packed_res = {1'b0, exp_n[7:0], mant[22:0]} + {31'd0, rnd};
	end

	always_ff @(posedge clk) begin
		res_s3 <= passc_s2 ? c_s2 : packed_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign done = v_s3;
	assign res  = res_s3;

endmodule

[rtl/core/dtf_datapath.sv]
// Datapath: byte buffer and string state, power table, accumulators, FMA and result register.
module dtf_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  dtf_pkg::dtf_cmd_t  cmd,
	output dtf_pkg::dtf_status_t status,
	input  logic               text_valid,
	output logic               text_stall,
	input  dtf_pkg::in_item_t  text,
	output logic               result_valid,
	input  logic               result_stall,
	output dtf_pkg::out_item_t result
);
	import dtf_pkg::*;

	function automatic logic [31:0] u8_to_fp(input logic [7:0] v);
		logic [2:0]  k;
		logic [31:0] wide;
		logic [7:0]  e;
		k = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (v[i]) k = 3'(i);
		end
		wide = {24'd0, v} << (5'd23 - {2'b0, k});
		e    = 8'd127 + {5'd0, k};
		if (v == 8'd0) return FP_ZERO;
		return {1'b0, e, wide[22:0]};
	endfunction

	// string state
	logic [7:0] buf_q [MaxDigits];
	logic [4:0] count_q;
	logic       neg_q;
	logic [4:0] point_q;
	logic       stopped_q;
	logic       ovf_q;
	logic       start_q;

	logic accept, do_store;
	assign accept     = text_valid & cmd.load_en;
	assign text_stall = ~cmd.load_en;
	assign do_store   = accept & (~start_q | ((text.character != "-") &&
		(text.character != "+")));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= 5'd0;
			neg_q     <= 1'b0;
			point_q   <= 5'(MaxDigits);
			stopped_q <= 1'b0;
			ovf_q     <= 1'b0;
			start_q   <= 1'b1;
		end else if (cmd.clear) begin
			count_q   <= 5'd0;
			neg_q     <= 1'b0;
			point_q   <= 5'(MaxDigits);
			stopped_q <= 1'b0;
			ovf_q     <= 1'b0;
			start_q   <= 1'b1;
		end else if (accept) begin
			start_q <= 1'b0;
			if (start_q && text.character == "-") begin
				neg_q <= 1'b1;
			end
			if (do_store) begin
				if (count_q[4]) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + 5'd1;
					if (!stopped_q && point_q == 5'(MaxDigits)) begin
						if (text.character == 8'd0) begin
							stopped_q <= 1'b1;
						end else if (text.character == ".") begin
							point_q <= count_q;
						end
					end
				end
			end
		end
	end

	// buffer write
	always_ff @(posedge clk) begin
		if (do_store && !count_q[4]) begin
			buf_q[count_q[3:0]] <= text.character;
		end
	end

	// lane operands
	logic [4:0]  pt, start, lane_idx, rd_idx;
	logic [7:0]  dig;
	logic [31:0] dig_fp;
	assign pt       = (point_q < count_q) ? point_q : count_q;
	assign start    = 5'(MaxDigits) - pt;
	assign lane_idx = start + {1'b0, cmd.lane};
	assign rd_idx   = cmd.use_lane ? lane_idx : cmd.tbl_rd;
	assign dig      = ({1'b0, cmd.lane} < count_q) ? (buf_q[cmd.lane] - "0") : 8'd0;
	assign dig_fp   = u8_to_fp(dig);

	// power table and accumulators
	logic [31:0] pow_q [2 * MaxDigits];
	logic [31:0] acc_a_q, acc_b_q, acc_p_q, acc_q_q;
	logic [31:0] pow_val, op_a, op_b, op_c, fma_res;
	logic        fma_done;

	always_comb begin
		if (rd_idx == POW_ONE_IDX) begin
			pow_val = FP_ONE;
		end else if (rd_idx == POW_POINT_IDX) begin
			pow_val = FP_ZERO;
		end else begin
			pow_val = pow_q[rd_idx];
		end
		case (cmd.a_sel)
			A_POW:   op_a = pow_val;
			A_ACC_A: op_a = acc_a_q;
			A_ACC_P: op_a = acc_p_q;
			default: op_a = acc_q_q;
		endcase
		case (cmd.b_sel)
			B_DIGIT: op_b = dig_fp;
			B_ONE:   op_b = FP_ONE;
			B_TEN:   op_b = FP_TEN;
			default: op_b = FP_TENTH;
		endcase
		case (cmd.c_sel)
			C_ZERO:  op_c = FP_ZERO;
			C_ACC_A: op_c = acc_a_q;
			C_ACC_B: op_c = acc_b_q;
			default: op_c = acc_q_q;
		endcase
	end

	dtf_fma u_fma (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (cmd.issue),
		.op_a   (op_a),
		.op_b   (op_b),
		.op_c   (op_c),
		.done   (fma_done),
		.res    (fma_res)
	);

	// write back of the finished operation
	always_ff @(posedge clk) begin
		if (fma_done) begin
			case (cmd.dst)
				D_ACC_A: acc_a_q <= fma_res;
				D_ACC_B: acc_b_q <= fma_res;
				D_ACC_P: acc_p_q <= fma_res;
				D_ACC_Q: acc_q_q <= fma_res;
				default: pow_q[cmd.tbl_wr] <= fma_res;
			endcase
		end
	end

	// result register
	logic      out_v_q;
	out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_v_q <= 1'b1;
		end else if (!result_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.too_long   <= ovf_q;
			out_q.value_bits <= ovf_q ? FP_ZERO : (acc_p_q ^ {neg_q, 31'd0});
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	assign status.last_acc = accept & text.last;
	assign status.overflow = ovf_q;
	assign status.fma_done = fma_done;
	assign status.out_full = out_v_q;

endmodule

[rtl/core/dtf_ctrl.sv]
// Controller: table build after reset, byte loading, FMA sequencing and result hand-off.
module dtf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dtf_pkg::dtf_status_t status,
	output dtf_pkg::dtf_cmd_t    cmd
);
	import dtf_pkg::*;

	state_t     state_q, state_n;
	logic [4:0] init_q;
	logic [1:0] grp_q;
	logic [2:0] step_q;
	logic       last_op;

	assign last_op = (grp_q == 2'd3) && (step_q == 3'd6);

	// state and sequence counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT_ISSUE;
			init_q  <= 5'd0;
			grp_q   <= 2'd0;
			step_q  <= 3'd0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_INIT_WAIT && status.fma_done) begin
				init_q <= init_q + 5'd1;
			end
			if (state_q == ST_LOAD) begin
				grp_q  <= 2'd0;
				step_q <= 3'd0;
			end else if (state_q == ST_EVAL_WAIT && status.fma_done && !last_op) begin
				if (step_q == 3'd5 && grp_q != 2'd3) begin
					grp_q  <= grp_q + 2'd1;
					step_q <= 3'd0;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_INIT_ISSUE: state_n = ST_INIT_WAIT;
			ST_INIT_WAIT: begin
				if (status.fma_done) begin
					state_n = (init_q == INIT_LAST) ? ST_LOAD : ST_INIT_ISSUE;
				end
			end
			ST_LOAD: begin
				if (status.last_acc) state_n = ST_CHECK;
			end
			ST_CHECK:      state_n = status.overflow ? ST_FINISH : ST_EVAL_ISSUE;
			ST_EVAL_ISSUE: state_n = ST_EVAL_WAIT;
			ST_EVAL_WAIT: begin
				if (status.fma_done) begin
					state_n = last_op ? ST_FINISH : ST_EVAL_ISSUE;
				end
			end
			ST_FINISH: begin
				if (!status.out_full) state_n = ST_LOAD;
			end
			default: state_n = ST_INIT_ISSUE;
		endcase
	end

	// outputs
	logic [4:0] wr_idx;
	logic       init_pos;

	always_comb begin
		init_pos = (init_q < 5'd15);
		wr_idx   = init_pos ? (5'd14 - init_q) : (init_q + 5'd2);

		cmd          = '0;
		cmd.a_sel    = A_POW;
		cmd.b_sel    = B_DIGIT;
		cmd.c_sel    = C_ZERO;
		cmd.dst      = D_ACC_A;

		unique case (state_q)
			ST_INIT_ISSUE, ST_INIT_WAIT: begin
				cmd.issue  = (state_q == ST_INIT_ISSUE);
				cmd.tbl_wr = wr_idx;
				if (init_pos) begin
					cmd.tbl_rd = wr_idx + 5'd1;
				end else if (wr_idx == 5'd17) begin
					cmd.tbl_rd = POW_ONE_IDX;
				end else begin
					cmd.tbl_rd = wr_idx - 5'd1;
				end
				cmd.b_sel = init_pos ? B_TEN : B_TENTH;
				cmd.dst   = D_TABLE;
			end
			ST_LOAD: cmd.load_en = 1'b1;
			ST_CHECK: ;
			ST_EVAL_ISSUE, ST_EVAL_WAIT: begin
				cmd.issue    = (state_q == ST_EVAL_ISSUE);
				cmd.use_lane = 1'b1;
				case (step_q)
					3'd0: begin
						cmd.lane = {2'd0, grp_q};
					end
					3'd1: begin
						cmd.lane = {2'd1, grp_q};
						cmd.dst  = D_ACC_B;
					end
					3'd2: begin
						cmd.lane  = {2'd2, grp_q};
						cmd.c_sel = C_ACC_A;
					end
					3'd3: begin
						cmd.lane  = {2'd3, grp_q};
						cmd.c_sel = C_ACC_B;
						cmd.dst   = D_ACC_B;
					end
					3'd4: begin
						cmd.a_sel = A_ACC_A;
						cmd.b_sel = B_ONE;
						cmd.c_sel = C_ACC_B;
					end
					3'd5: begin
						cmd.b_sel = B_ONE;
						case (grp_q)
							2'd0: begin
								cmd.a_sel = A_ACC_A;
								cmd.dst   = D_ACC_P;
							end
							2'd1: begin
								cmd.a_sel = A_ACC_P;
								cmd.c_sel = C_ACC_A;
								cmd.dst   = D_ACC_P;
							end
							2'd2: begin
								cmd.a_sel = A_ACC_A;
								cmd.dst   = D_ACC_Q;
							end
							default: begin
								cmd.a_sel = A_ACC_Q;
								cmd.c_sel = C_ACC_A;
								cmd.dst   = D_ACC_Q;
							end
						endcase
					end
					default: begin
						// final sum of the two halves
						cmd.a_sel = A_ACC_P;
						cmd.b_sel = B_ONE;
						cmd.c_sel = C_ACC_Q;
						cmd.dst   = D_ACC_P;
					end
				endcase
			end
			ST_FINISH: begin
				cmd.out_load = ~status.out_full;
				cmd.clear    = ~status.out_full;
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/decimal_text_to_float32_core.sv]
// After the last byte of a string its 25 FMA operations run before the result; a too-long string skips them.
// Throughput: one byte per cycle while loading; the string is then evaluated with one shared
// three-stage FMA, 25 operations per string.
// After reset the power table is built by the same FMA: 30 operations, stall held high.
// Reset (arst_n low, asynchronous) clears the string state, the sequencer and the result valid.
module decimal_text_to_float32_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               text_valid,
	output logic               text_stall,
	input  dtf_pkg::in_item_t  text,
	output logic               result_valid,
	input  logic               result_stall,
	output dtf_pkg::out_item_t result
);
	import dtf_pkg::*;

	dtf_cmd_t    cmd;
	dtf_status_t status;

	dtf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	dtf_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text         (text),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[rtl/core/dtf_checker.sv]
// Port-level checker for the text-to-float core, bound to the top level.
module dtf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               text_valid,
	input logic               text_stall,
	input dtf_pkg::in_item_t  text,
	input logic               result_valid,
	input logic               result_stall,
	input dtf_pkg::out_item_t result
);
	import dtf_pkg::*;

	// a stalled result transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a too-long string reports zero
	a_too_long_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.too_long |-> result.value_bits == 32'd0)
		else $error("too_long with nonzero value");

	// the block stops taking bytes once a string ends
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_stall && text.last |=> text_stall)
		else $error("byte taken right after last byte");

	// no new result appears while a string is still loading
	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(text_stall))
		else $error("result appeared during loading");

endmodule

bind decimal_text_to_float32_core dtf_checker u_dtf_checker (.*);
